// ===== rtl/lpam_pkg.sv =====
// LED panel pixel address mapper: shared constants and types.
// Used by the channel interfaces and the top level; no dependencies.
`timescale 1ns / 1ps

package lpam_pkg;

  localparam int LEDS_PER_STRIP    = 8;
  localparam int STRIPS_PER_PANEL  = 20;
  localparam int PANELS_PER_STRAND = 2;
  localparam int STRAND_COUNT      = 3;
  localparam int MAX_PANELS        = PANELS_PER_STRAND * STRAND_COUNT;
  localparam int LEDS_PER_PANEL    = LEDS_PER_STRIP * STRIPS_PER_PANEL;
  localparam int LEDS_PER_STRAND   = LEDS_PER_PANEL * PANELS_PER_STRAND;

  localparam int POS_W      = 12;
  localparam int COLOR_W    = 8;
  localparam int STRAND_W   = 2;
  localparam int LED_W      = 9;
  localparam int GRB_W      = 24;
  localparam int PANEL_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PANELS_ACROSS = 3'd0,
    REG_PANELS_DOWN   = 3'd1,
    REG_VERTICAL_MODE = 3'd2,
    REG_FLIP_X        = 3'd3,
    REG_FLIP_Y        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PANEL_W-1:0] panels_across;
    logic [PANEL_W-1:0] panels_down;
    logic               vertical_mode;
    logic               flip_x;
    logic               flip_y;
  } geom_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                accepted;
    logic [STRAND_W-1:0] strand_sel;
    logic [LED_W-1:0]    led_index;
    logic [GRB_W-1:0]    grb_word;
  } result_t;

endpackage

// ===== rtl/lpam_if.sv =====
// Valid/ready channel interfaces for pixel requests and mapped LED results.
// Depends on lpam_pkg for field widths.
`timescale 1ns / 1ps

interface lpam_in_if;
  logic                        valid;
  logic                        ready;
  logic [lpam_pkg::POS_W-1:0]   pos_x;
  logic [lpam_pkg::POS_W-1:0]   pos_y;
  logic [lpam_pkg::COLOR_W-1:0] red;
  logic [lpam_pkg::COLOR_W-1:0] green;
  logic [lpam_pkg::COLOR_W-1:0] blue;

  modport source (output valid, pos_x, pos_y, red, green, blue, input ready);
  modport sink   (input valid, pos_x, pos_y, red, green, blue, output ready);
endinterface

interface lpam_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [lpam_pkg::STRAND_W-1:0] strand_sel;
  logic [lpam_pkg::LED_W-1:0]    led_index;
  logic [lpam_pkg::GRB_W-1:0]    grb_word;

  modport source (output valid, accepted, strand_sel, led_index, grb_word, input ready);
  modport sink   (input valid, accepted, strand_sel, led_index, grb_word, output ready);
endinterface

// ===== rtl/led_panel_pixel_address_mapper.sv =====
// LED panel pixel address mapper, top level.
// Depends on lpam_pkg and the channel interfaces in lpam_if.sv.
`timescale 1ns / 1ps
//
// Usage:
//   in_px  : pixel requests (pos_x, pos_y, red, green, blue), valid/ready.
//   out_px : one result per request (accepted, strand_sel, led_index,
//            grb_word), valid/ready, in request order.
//   cfg_*  : register write port; cfg_addr selects panels_across,
//            panels_down, vertical_mode, flip_x or flip_y. Unknown indexes
//            are ignored. Write only while no request is in flight.
// Timing:
//   Pipeline: an input register, then the mapping logic into the result
//   register. Throughput is one request per cycle while the output is not stalled.
//   A rejected pixel gives accepted = 0 and all other fields zero.
// Reset:
//   Synchronous, active low. Both stages empty; geometry returns to one
//   panel across, one down, horizontal, no mirroring.
// Stall:
//   When out_px.ready is low the result holds; one more request is taken
//   into the input register, then in_px.ready drops until the result goes.

module led_panel_pixel_address_mapper (
  input  logic                                clk,
  input  logic                                rst_n,
  lpam_in_if.sink                             in_px,
  lpam_out_if.source                          out_px,
  input  logic                                cfg_we,
  input  logic [lpam_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lpam_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int XW     = lpam_pkg::POS_W;
  localparam int NARROW = 8;
  localparam int X_LIMIT = lpam_pkg::STRIPS_PER_PANEL * (1 << lpam_pkg::PANEL_W);
  localparam int PIDX_W = 2 * lpam_pkg::PANEL_W;

  lpam_pkg::geom_t   geom_r;
  lpam_pkg::pixel_t  pix_r;
  lpam_pkg::result_t res_r;
  lpam_pkg::result_t res_nxt;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              s1_ready;
  logic              s2_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.panels_across <= 3'd1;
      geom_r.panels_down   <= 3'd1;
      geom_r.vertical_mode <= 1'b0;
      geom_r.flip_x        <= 1'b0;
      geom_r.flip_y        <= 1'b0;
    end else if (cfg_we) begin
      case (lpam_pkg::cfg_reg_t'(cfg_addr))
        lpam_pkg::REG_PANELS_ACROSS: geom_r.panels_across <= cfg_wdata;
        lpam_pkg::REG_PANELS_DOWN:   geom_r.panels_down   <= cfg_wdata;
        lpam_pkg::REG_VERTICAL_MODE: geom_r.vertical_mode <= cfg_wdata[0];
        lpam_pkg::REG_FLIP_X:        geom_r.flip_x        <= cfg_wdata[0];
        lpam_pkg::REG_FLIP_Y:        geom_r.flip_y        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // mapping logic
  logic [NARROW-1:0]           scr_w;
  logic [NARROW-1:0]           scr_h;
  logic [NARROW-1:0]           pw;
  logic [NARROW-1:0]           ph;
  logic [XW-1:0]               x_m;
  logic [XW-1:0]               y_m;
  logic [XW-1:0]               x_s;
  logic [XW-1:0]               y_s;
  logic [NARROW-1:0]           x8;
  logic [lpam_pkg::PANEL_W-1:0] px;
  logic [NARROW-1:0]           x_mod;
  logic [XW-4:0]               py;
  logic [2:0]                  y_mod;
  logic [PIDX_W-1:0]           pidx;
  logic                        pin;
  logic                        reject;

  always_comb begin
    pw = geom_r.vertical_mode ? NARROW'(lpam_pkg::LEDS_PER_STRIP)
                              : NARROW'(lpam_pkg::STRIPS_PER_PANEL);
    ph = geom_r.vertical_mode ? NARROW'(lpam_pkg::STRIPS_PER_PANEL)
                              : NARROW'(lpam_pkg::LEDS_PER_STRIP);
    scr_w = NARROW'({5'd0, geom_r.panels_across} * pw);
    scr_h = NARROW'({5'd0, geom_r.panels_down} * ph);
    reject = (geom_r.panels_across == '0);

    x_m = pix_r.pos_x;
    if (geom_r.flip_x) begin
      reject = reject | (pix_r.pos_x >= {4'd0, scr_w});
      x_m = {4'd0, scr_w} - 12'd1 - pix_r.pos_x;
    end
    y_m = pix_r.pos_y;
    if (geom_r.flip_y) begin
      reject = reject | (pix_r.pos_y >= {4'd0, scr_h});
      y_m = {4'd0, scr_h} - 12'd1 - pix_r.pos_y;
    end
    x_s = geom_r.vertical_mode ? y_m : x_m;
    y_s = geom_r.vertical_mode ? x_m : y_m;

    // column past eight panels can never be on the grid
    reject = reject | (x_s >= XW'(X_LIMIT));
    x8 = x_s[NARROW-1:0];
    px = '0;
    for (int k = 1; k < (1 << lpam_pkg::PANEL_W); k++) begin
      if (x8 >= NARROW'(k * lpam_pkg::STRIPS_PER_PANEL)) px = lpam_pkg::PANEL_W'(k);
    end
    x_mod = x8 - NARROW'(int'(px) * lpam_pkg::STRIPS_PER_PANEL);

    py    = (XW-3)'(y_s / lpam_pkg::LEDS_PER_STRIP);
    y_mod = 3'(y_s % lpam_pkg::LEDS_PER_STRIP);

    reject = reject | (px >= geom_r.panels_across)
                    | (py >= {6'd0, geom_r.panels_down});
    pidx = {3'd0, px} + PIDX_W'({3'd0, py[2:0]} * {3'd0, geom_r.panels_across});
    reject = reject | (pidx >= PIDX_W'(lpam_pkg::MAX_PANELS));
    pin = 1'(pidx % lpam_pkg::PANELS_PER_STRAND);

    res_nxt = '0;
    if (!reject) begin
      res_nxt.accepted   = 1'b1;
      res_nxt.strand_sel = lpam_pkg::STRAND_W'(pidx / lpam_pkg::PANELS_PER_STRAND);
      res_nxt.led_index  = lpam_pkg::LED_W'(int'(pin) * lpam_pkg::LEDS_PER_PANEL
                         + int'(x_mod) * lpam_pkg::LEDS_PER_STRIP + int'(y_mod));
      res_nxt.grb_word   = {pix_r.green, pix_r.red, pix_r.blue};
    end
  end

  // two-stage pipeline control
  assign s2_ready    = !out_valid_r || out_px.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_px.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r  <= in_px.valid;
      if (s2_ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_px.valid && s1_ready) begin
      pix_r.pos_x <= in_px.pos_x;
      pix_r.pos_y <= in_px.pos_y;
      pix_r.red   <= in_px.red;
      pix_r.green <= in_px.green;
      pix_r.blue  <= in_px.blue;
    end
    if (s1_valid_r && s2_ready) res_r <= res_nxt;
  end

  assign out_px.valid      = out_valid_r;
  assign out_px.accepted   = res_r.accepted;
  assign out_px.strand_sel = res_r.strand_sel;
  assign out_px.led_index  = res_r.led_index;
  assign out_px.grb_word   = res_r.grb_word;

  // assertions
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && res_r.accepted |->
        (res_r.led_index < lpam_pkg::LED_W'(lpam_pkg::LEDS_PER_STRAND))
        && (res_r.strand_sel < lpam_pkg::STRAND_W'(lpam_pkg::STRAND_COUNT)))
    else $error("mapped LED address out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && !res_r.accepted |->
        (res_r.strand_sel == '0) && (res_r.led_index == '0) && (res_r.grb_word == '0))
    else $error("rejected pixel carries nonzero fields");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_px.ready && s1_valid_r |-> !in_px.ready)
    else $error("input taken while both stages are full and stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
      $past(!rst_n) |-> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for led_panel_pixel_address_mapper: random pixel requests
// across many panel geometries, checked against an in-bench mapping model.
// Depends on lpam_pkg, the channel interfaces in lpam_if.sv and the RTL top.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 200;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_NOTES    = 50;
  localparam logic [lpam_pkg::CFG_ADDR_W-1:0] FIRST_UNUSED_REG =
    lpam_pkg::REG_FLIP_Y + 1'b1;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lpam_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lpam_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lpam_in_if  in_px ();
  lpam_out_if out_px ();

  led_panel_pixel_address_mapper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (in_px),
    .out_px   (out_px),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  lpam_pkg::geom_t   geom;
  lpam_pkg::pixel_t  pixel_q[$];
  lpam_pkg::result_t led_q[$];

  bit in_taken;
  bit out_taken;
  bit snd_steady;
  bit rcv_steady;
  bit hold_armed;
  int send_gap;
  int stall_left;
  int cycles;
  int mismatches;
  int n_requests;
  int n_mapped;
  int n_rejected;
  int n_geoms;

  always #4 clk = ~clk;

  // Expected LED address for one pixel under the given geometry.
  function automatic lpam_pkg::result_t map_pixel(input lpam_pkg::pixel_t p,
                                                  input lpam_pkg::geom_t g);
    int x, y, t, pa, pd, pw, ph, w, h, px, py, idx;
    lpam_pkg::result_t r;
    r  = '0;
    x  = int'(p.pos_x);
    y  = int'(p.pos_y);
    pa = int'(g.panels_across);
    pd = int'(g.panels_down);
    pw = g.vertical_mode ? lpam_pkg::LEDS_PER_STRIP : lpam_pkg::STRIPS_PER_PANEL;
    ph = g.vertical_mode ? lpam_pkg::STRIPS_PER_PANEL : lpam_pkg::LEDS_PER_STRIP;
    w  = pa * pw;
    h  = pd * ph;
    if (g.flip_x) begin
      if (x >= w) return r;
      x = w - x - 1;
    end
    if (g.flip_y) begin
      if (y >= h) return r;
      y = h - y - 1;
    end
    if (g.vertical_mode) begin
      t = x;
      x = y;
      y = t;
    end
    if (pa == 0) return r;
    px = x / lpam_pkg::STRIPS_PER_PANEL;
    py = y / lpam_pkg::LEDS_PER_STRIP;
    if (px >= pa || py >= pd) return r;
    idx = px + py * pa;
    if (idx >= lpam_pkg::MAX_PANELS) return r;
    r.accepted   = 1'b1;
    r.strand_sel = lpam_pkg::STRAND_W'(idx / lpam_pkg::PANELS_PER_STRAND);
    r.led_index  = lpam_pkg::LED_W'(
                     lpam_pkg::LEDS_PER_PANEL * (idx % lpam_pkg::PANELS_PER_STRAND)
                   + lpam_pkg::LEDS_PER_STRIP * (x % lpam_pkg::STRIPS_PER_PANEL)
                   + (y % lpam_pkg::LEDS_PER_STRIP));
    r.grb_word   = {p.green, p.red, p.blue};
    return r;
  endfunction

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    if (mismatches < MAX_NOTES)
      $display("mismatch @%0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Request side: launch queued pixels, with a random gap after each one unless snd_steady.
  always @(negedge clk) begin
    lpam_pkg::pixel_t nxt;
    if (rst_n && (!in_px.valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_px.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        nxt = pixel_q.pop_front();
        in_px.pos_x <= nxt.pos_x;
        in_px.pos_y <= nxt.pos_y;
        in_px.red   <= nxt.red;
        in_px.green <= nxt.green;
        in_px.blue  <= nxt.blue;
        in_px.valid <= 1'b1;
        send_gap = snd_steady ? 0 : $urandom_range(0, 16);
      end else begin
        in_px.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall after each result unless rcv_steady, plus one long hold-off.
  always @(negedge clk) begin
    if (out_taken) stall_left = rcv_steady ? 0 : $urandom_range(0, 16);
    if (hold_armed) begin
      hold_armed = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_px.ready <= 1'b0;
    end else begin
      out_px.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lpam_pkg::pixel_t  p;
    lpam_pkg::result_t got;
    lpam_pkg::result_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end else begin
      in_taken  <= rst_n && in_px.valid && in_px.ready;
      out_taken <= rst_n && out_px.valid && out_px.ready;
      if (rst_n && out_px.valid && out_px.ready) begin
        got = {out_px.accepted, out_px.strand_sel, out_px.led_index, out_px.grb_word};
        if (led_q.size() == 0) begin
          report("unrequested result", 32'd0, 32'(got.grb_word));
        end else begin
          want = led_q.pop_front();
          if (got.accepted !== want.accepted)
            report("accepted", 32'(want.accepted), 32'(got.accepted));
          if (got.strand_sel !== want.strand_sel)
            report("strand_sel", 32'(want.strand_sel), 32'(got.strand_sel));
          if (got.led_index !== want.led_index)
            report("led_index", 32'(want.led_index), 32'(got.led_index));
          if (got.grb_word !== want.grb_word)
            report("grb_word", 32'(want.grb_word), 32'(got.grb_word));
        end
      end
      if (rst_n && in_px.valid && in_px.ready) begin
        p    = {in_px.pos_x, in_px.pos_y, in_px.red, in_px.green, in_px.blue};
        want = map_pixel(p, geom);
        led_q.push_back(want);
        n_requests++;
        if (want.accepted) n_mapped++;
        else n_rejected++;
      end
    end
  end

  task automatic wait_idle;
    while (pixel_q.size() != 0 || in_px.valid || led_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [lpam_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [lpam_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      lpam_pkg::REG_PANELS_ACROSS: geom.panels_across = val;
      lpam_pkg::REG_PANELS_DOWN:   geom.panels_down   = val;
      lpam_pkg::REG_VERTICAL_MODE: geom.vertical_mode = val[0];
      lpam_pkg::REG_FLIP_X:        geom.flip_x        = val[0];
      lpam_pkg::REG_FLIP_Y:        geom.flip_y        = val[0];
      default: ;
    endcase
  endtask

  task automatic push_pixel(input int x, input int y, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    lpam_pkg::pixel_t p;
    p.pos_x = x[lpam_pkg::POS_W-1:0];
    p.pos_y = y[lpam_pkg::POS_W-1:0];
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pixel_q.push_back(p);
  endtask

  // Mostly near the screen, some past the edges, some anywhere in the field range.
  task automatic push_random(input int w, input int h);
    int kind, x, y;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      x = $urandom_range(0, w + 2);
      y = $urandom_range(0, h + 2);
    end else if (kind < 17) begin
      x = $urandom_range(0, 2 * w + 40);
      y = $urandom_range(0, 2 * h + 40);
    end else begin
      x = $urandom;
      y = $urandom;
    end
    push_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_phase(input logic [2:0] pa, input logic [2:0] pd, input logic vm,
                           input logic fx, input logic fy, input bit snd_fast,
                           input bit rcv_fast, input bit long_hold);
    int w, h;
    wait_idle();
    cfg_write(lpam_pkg::REG_PANELS_ACROSS, pa);
    cfg_write(lpam_pkg::REG_PANELS_DOWN, pd);
    cfg_write(lpam_pkg::REG_VERTICAL_MODE, {2'($urandom), vm});
    cfg_write(lpam_pkg::REG_FLIP_X, {2'($urandom), fx});
    cfg_write(lpam_pkg::REG_FLIP_Y, {2'($urandom), fy});
    cfg_write(FIRST_UNUSED_REG + lpam_pkg::CFG_ADDR_W'($urandom_range(0, 2)),
              lpam_pkg::CFG_DATA_W'($urandom));
    n_geoms++;
    snd_steady = snd_fast;
    rcv_steady = rcv_fast;
    if (long_hold) hold_armed = 1'b1;
    w = int'(pa) * (vm ? lpam_pkg::LEDS_PER_STRIP : lpam_pkg::STRIPS_PER_PANEL);
    h = int'(pd) * (vm ? lpam_pkg::STRIPS_PER_PANEL : lpam_pkg::LEDS_PER_STRIP);
    push_pixel(0, 0, 8'($urandom), 8'($urandom), 8'($urandom));
    push_pixel(w - 1, h - 1, 8'($urandom), 8'($urandom), 8'($urandom));
    push_pixel(w, 0, 8'($urandom), 8'($urandom), 8'($urandom));
    push_pixel(0, h, 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (PHASE_ITEMS) push_random(w, h);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_px.valid  = 1'b0;
    in_px.pos_x  = '0;
    in_px.pos_y  = '0;
    in_px.red    = '0;
    in_px.green  = '0;
    in_px.blue   = '0;
    out_px.ready = 1'b0;
    geom         = '{panels_across: 3'd1, panels_down: 3'd1, vertical_mode: 1'b0,
                     flip_x: 1'b0, flip_y: 1'b0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: one horizontal panel, corners and color extremes
    n_geoms = 1;
    push_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    push_pixel(19, 7, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(20, 0, 8'hAA, 8'h55, 8'hAA);
    push_pixel(0, 8, 8'h55, 8'hAA, 8'h55);
    push_pixel(4095, 4095, 8'hFF, 8'h00, 8'h00);
    push_pixel(4095, 0, 8'h00, 8'hFF, 8'h00);
    push_pixel(0, 4095, 8'h00, 8'h00, 8'hFF);
    push_pixel(10, 3, 8'h81, 8'h18, 8'h7E);
    push_pixel(2730, 1365, 8'h01, 8'h80, 8'h3C);
    push_pixel(1365, 2730, 8'h80, 8'h01, 8'hC3);

    run_phase(3'd6, 3'd6, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(3'd6, 3'd6, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(3'd3, 3'd2, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    run_phase(3'd0, 3'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(3'd0, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    run_phase(3'd2, 3'd3, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    run_phase(3'd1, 3'd6, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(3'd6, 3'd1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(3'd7, 3'd7, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(3'd7, 3'd7, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    run_phase(3'd5, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(3'd2, 3'd2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (3) begin
      run_phase(3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                1'b0, 1'b0, 1'b0);
    end
    run_phase(3'd1, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_idle();

    $display("covered %0d pixel requests over %0d panel geometries", n_requests, n_geoms);
    $display("%0d mapped to an LED, %0d rejected, %0d mismatches",
             n_mapped, n_rejected, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
